@@ sv/gmi_pkg.sv @@
// gmi_pkg: shared types, codes and constants of the genetic map interpolator.
// Used by gmi_alu, genetic_map_interpolator and the bench; depends on nothing.
package gmi_pkg;

    localparam int TABLE_DEPTH_DEF = 65536;
    localparam int LOOKBACK_DEF    = 64;

    localparam int WIDE_W     = 128;   // shared unit datapath
    localparam int MUL_B_W    = 64;    // multiplier bits consumed per product
    localparam int KIND_W     = 3;
    localparam int VAL_W      = 32;
    localparam int CMR_W      = 32;
    localparam int BPR_W      = 40;
    localparam int STATUS_W   = 3;
    localparam int SLOPE_W    = 64;
    localparam int FRAC_BP    = 8;     // fraction bits of a bp answer
    localparam int SH_CM      = 32;    // 32.32 slope product down to cM
    localparam int SH_BP      = 24;    // 32.32 slope product down to bp.8

    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BP2CM = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CM2BP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_EXACT  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INTERP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BELOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABOVE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNFIT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ORDER  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd7;

    // edge slope slots: {window end, bp per cM}
    localparam logic [1:0] SLP_BEG_CM = 2'd0;
    localparam logic [1:0] SLP_BEG_BP = 2'd1;
    localparam logic [1:0] SLP_END_CM = 2'd2;
    localparam logic [1:0] SLP_END_BP = 2'd3;

    localparam logic [WIDE_W-1:0] HALF_CM = WIDE_W'(64'h8000_0000);
    localparam logic [WIDE_W-1:0] HALF_BP = WIDE_W'(64'h80_0000);
    localparam logic [WIDE_W-1:0] MAX_CM  = WIDE_W'(64'hFFFF_FFFF);
    localparam logic [WIDE_W-1:0] MAX_BP  = WIDE_W'(64'hFF_FFFF_FFFF);

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [WIDE_W-1:0] a;    // multiplicand or dividend
        logic [WIDE_W-1:0] b;    // multiplier or divisor
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] quo;  // product or quotient
        logic [WIDE_W-1:0] rem;
    } t_alu_rsp;

endpackage

@@ sv/gmi_ram.sv @@
// gmi_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/gmi_alu.sv @@
// gmi_alu: shared serial unit, shift-add multiply (64 steps) and restoring
// divide (128 steps), one step per cycle. Depends on gmi_pkg.
module gmi_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gmi_pkg::t_alu_req i_req,
    output gmi_pkg::t_alu_rsp o_rsp
);
    import gmi_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W + 1);
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MUL_B_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(WIDE_W);

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIDE_W-1:0] r_acc;   // product accumulator / partial remainder
    logic [WIDE_W-1:0] r_a;     // shifted multiplicand / dividend bits
    logic [WIDE_W-1:0] r_b;     // shifted multiplier / divisor
    logic [WIDE_W-1:0] r_quo;

    logic [WIDE_W-1:0] rem_s;
    logic [WIDE_W-1:0] rem_diff;
    logic              take;

    assign rem_s    = {r_acc[WIDE_W-2:0], r_a[WIDE_W-1]};
    assign rem_diff = rem_s - r_b;
    assign take     = r_acc[WIDE_W-1] || (rem_s >= r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == ALU_MUL) ? MUL_STEPS : DIV_STEPS;
                r_acc  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_quo  <= '0;
            end else if (r_busy) begin
                case (r_op)
                    ALU_MUL: begin
                        if (r_b[0]) begin
                            r_acc <= r_acc + r_a;
                        end
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                    end
                    ALU_DIV: begin
                        r_acc <= take ? rem_diff : rem_s;
                        r_a   <= r_a << 1;
                        r_quo <= {r_quo[WIDE_W-2:0], take};
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = (r_op == ALU_MUL) ? r_acc : r_quo;
    assign o_rsp.rem  = r_acc;

endmodule

@@ sv/genetic_map_interpolator.sv @@
// genetic_map_interpolator: top level, sequencer around the map tables and
// the shared serial unit. Depends on gmi_pkg, gmi_ram and gmi_alu.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one transaction per
//   item: kind, bp_value, cm_value. Output channel (o_out_valid /
//   i_out_stall) returns exactly one transaction per item: cm_result,
//   bp_result, status, saturated. Fields that do not apply are zero.
//   Points are loaded in ascending order (kind 1); a fit (kind 2) must
//   follow the last load before queries (kinds 3 and 4) are answered.
// Operation (one item at a time, o_in_stall high while busy)
//   clear, load, rejected items and unanswered queries: straight to the result.
//   query: a binary search over the table RAMs; an exact hit ends there.
//     Outside the table one serial multiply follows; between two points
//     the multiply plus a serial divide.
//   fit: per window (first and last min(points, LOOKBACK) points) three
//     serial products per point, then six products and two divides (a
//     divide is skipped when its denominator is zero); two windows per fit.
// Reset clears the point count, edge slopes and fit flag; table RAM
//   contents are not cleared. A finished result sits in the output register
//   while the receiver stalls; the next item is still accepted and runs up
//   to its own result, then waits until the register drains.
module genetic_map_interpolator #(
    parameter int TABLE_DEPTH = gmi_pkg::TABLE_DEPTH_DEF,
    parameter int LOOKBACK    = gmi_pkg::LOOKBACK_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gmi_pkg::KIND_W-1:0]    i_kind,
    input  logic [gmi_pkg::VAL_W-1:0]     i_bp_value,
    input  logic [gmi_pkg::VAL_W-1:0]     i_cm_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gmi_pkg::CMR_W-1:0]     o_cm_result,
    output logic [gmi_pkg::BPR_W-1:0]     o_bp_result,
    output logic [gmi_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_saturated
);
    import gmi_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LB_W  = $clog2(LOOKBACK + 1);
    localparam int SX_W  = VAL_W + LB_W;       // sum of offsets
    localparam int SQ_W  = 2 * VAL_W + LB_W;   // sum of offset products
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIT_RD,
        S_FIT_CAP,
        S_ALU_GO,
        S_ALU_WAIT,
        S_SLOPE,
        S_WEND,
        S_SRCH,
        S_CMP,
        S_QA,
        S_QB,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        STP_DXX,
        STP_DYY,
        STP_DXY,
        STP_NSXX,
        STP_SXSX,
        STP_NSYY,
        STP_SYSY,
        STP_NSXY,
        STP_SXSY,
        STP_SLP_A,
        STP_SLP_B,
        STP_BELOW,
        STP_ABOVE,
        STP_NUM,
        STP_DIV
    } t_step;

    function automatic logic [SLOPE_W-1:0] f_sat(input logic [WIDE_W-1:0] v);
        f_sat = (|v[WIDE_W-1:SLOPE_W]) ? '1 : v[SLOPE_W-1:0];
    endfunction

    // control
    t_state              r_state;
    t_step               r_step;
    logic [CNT_W-1:0]    r_count;
    logic                r_ready;
    logic [SLOPE_W-1:0]  r_slope [4];
    logic                r_out_valid;

    // item and working registers
    logic [KIND_W-1:0]   r_kind;
    logic [VAL_W-1:0]    r_q;
    logic [VAL_W-1:0]    r_last_bp;
    logic [VAL_W-1:0]    r_last_cm;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [VAL_W-1:0]    r_ka;
    logic [VAL_W-1:0]    r_va;
    logic [VAL_W-1:0]    r_kb;
    logic [VAL_W-1:0]    r_vb;
    logic                r_win;
    logic [CNT_W-1:0]    r_base;
    logic [CNT_W-1:0]    r_end_base;
    logic [LB_W-1:0]     r_n;
    logic [LB_W-1:0]     r_k;
    logic [VAL_W-1:0]    r_x0;
    logic [VAL_W-1:0]    r_y0;
    logic [VAL_W-1:0]    r_dx;
    logic [VAL_W-1:0]    r_dy;
    logic [SX_W-1:0]     r_sx;
    logic [SX_W-1:0]     r_sy;
    logic [SQ_W-1:0]     r_sxx;
    logic [SQ_W-1:0]     r_syy;
    logic [SQ_W-1:0]     r_sxy;
    logic [WIDE_W-1:0]   r_t1;
    logic [WIDE_W-1:0]   r_dxx;
    logic [WIDE_W-1:0]   r_dyy;
    logic [WIDE_W-1:0]   r_dxy;
    logic [BPR_W-1:0]    r_res;
    logic [STATUS_W-1:0] r_status;
    logic                r_sat;
    logic [CMR_W-1:0]    r_o_cm;
    logic [BPR_W-1:0]    r_o_bp;
    logic [STATUS_W-1:0] r_o_status;
    logic                r_o_sat;

    // memories and shared unit
    logic [AW-1:0]       n_rd_addr;
    logic                wr_en;
    logic [VAL_W-1:0]    pos_rd;
    logic [VAL_W-1:0]    dist_rd;
    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    // misc combinational
    logic                accept;
    logic                load_bad_order;
    logic [CNT_W:0]      mid_sum;
    logic [CNT_W-1:0]    mid;
    logic                is_bp;
    logic [VAL_W-1:0]    key;
    logic [VAL_W-1:0]    val;
    logic [LB_W-1:0]     fit_n;
    logic [CNT_W-1:0]    fit_e;
    logic [CNT_W-1:0]    pt_addr;
    logic [VAL_W-1:0]    cap_x0;
    logic [VAL_W-1:0]    cap_y0;
    logic [SLOPE_W-1:0]  slope_beg;
    logic [SLOPE_W-1:0]  slope_end;
    logic [WIDE_W-1:0]   q_half;
    logic [WIDE_W-1:0]   q_max;
    logic [WIDE_W-1:0]   q_base;
    logic [WIDE_W-1:0]   q_below_pre;
    logic [WIDE_W-1:0]   q_above_pre;
    logic [WIDE_W-1:0]   q_below;
    logic [WIDE_W-1:0]   q_above;
    logic [WIDE_W-1:0]   q_den;
    logic                q_round;
    logic [WIDE_W-1:0]   q_vb_sh;
    logic [WIDE_W-1:0]   q_interp;
    logic [WIDE_W-1:0]   num_sh;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign load_bad_order = (r_count != '0) &&
                            ((i_bp_value <= r_last_bp) || (i_cm_value <= r_last_cm));
    assign wr_en = accept && (i_kind == KIND_LOAD) && (r_count != DEPTH_CNT) &&
                   !load_bad_order;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CNT_W:1];

    assign is_bp = (r_kind == KIND_CM2BP);
    assign key   = is_bp ? dist_rd : pos_rd;
    assign val   = is_bp ? pos_rd : dist_rd;

    assign fit_n = (32'(r_count) < 32'(LOOKBACK)) ? LB_W'(r_count) : LB_W'(LOOKBACK);
    assign fit_e = r_count - CNT_W'(fit_n);

    assign pt_addr = r_base + CNT_W'(r_k);
    assign cap_x0  = (r_k == '0) ? pos_rd : r_x0;
    assign cap_y0  = (r_k == '0) ? dist_rd : r_y0;

    assign slope_beg = is_bp ? r_slope[SLP_BEG_BP] : r_slope[SLP_BEG_CM];
    assign slope_end = is_bp ? r_slope[SLP_END_BP] : r_slope[SLP_END_CM];

    // extrapolation and interpolation arithmetic around the unit's result
    assign q_half      = is_bp ? HALF_BP : HALF_CM;
    assign q_max       = is_bp ? MAX_BP : MAX_CM;
    assign q_base      = WIDE_W'({r_va, 32'h0});
    assign q_below_pre = q_base - alu_rsp.quo + q_half;
    assign q_above_pre = q_base + alu_rsp.quo + q_half;
    assign q_below     = is_bp ? (q_below_pre >> SH_BP) : (q_below_pre >> SH_CM);
    assign q_above     = is_bp ? (q_above_pre >> SH_BP) : (q_above_pre >> SH_CM);
    assign q_den       = WIDE_W'(r_ka - r_kb);
    assign q_round     = ({alu_rsp.rem[WIDE_W-2:0], 1'b0} >= q_den);
    assign q_vb_sh     = is_bp ? (WIDE_W'(r_vb) << FRAC_BP) : WIDE_W'(r_vb);
    assign q_interp    = q_vb_sh + alu_rsp.quo + WIDE_W'(q_round);
    assign num_sh      = is_bp ? (r_t1 << FRAC_BP) : r_t1;

    // RAM read address
    always_comb begin
        n_rd_addr = '0;
        case (r_state)
            S_FIT_RD: n_rd_addr = pt_addr[AW-1:0];
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_rd_addr = mid[AW-1:0];
                end else if (r_lo < r_count) begin
                    n_rd_addr = r_lo[AW-1:0];
                end else begin
                    n_rd_addr = AW'(r_count - 1'b1);
                end
            end
            S_QA:     n_rd_addr = AW'(r_lo - 1'b1);
            default:  n_rd_addr = '0;
        endcase
    end

    // shared unit request
    always_comb begin
        alu_req.start = (r_state == S_ALU_GO);
        alu_req.op    = ALU_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;
        case (r_step)
            STP_DXX:   begin alu_req.a = WIDE_W'(r_dx);  alu_req.b = WIDE_W'(r_dx); end
            STP_DYY:   begin alu_req.a = WIDE_W'(r_dy);  alu_req.b = WIDE_W'(r_dy); end
            STP_DXY:   begin alu_req.a = WIDE_W'(r_dx);  alu_req.b = WIDE_W'(r_dy); end
            STP_NSXX:  begin alu_req.a = WIDE_W'(r_sxx); alu_req.b = WIDE_W'(r_n);  end
            STP_SXSX:  begin alu_req.a = WIDE_W'(r_sx);  alu_req.b = WIDE_W'(r_sx); end
            STP_NSYY:  begin alu_req.a = WIDE_W'(r_syy); alu_req.b = WIDE_W'(r_n);  end
            STP_SYSY:  begin alu_req.a = WIDE_W'(r_sy);  alu_req.b = WIDE_W'(r_sy); end
            STP_NSXY:  begin alu_req.a = WIDE_W'(r_sxy); alu_req.b = WIDE_W'(r_n);  end
            STP_SXSY:  begin alu_req.a = WIDE_W'(r_sx);  alu_req.b = WIDE_W'(r_sy); end
            STP_SLP_A: begin
                alu_req.op = ALU_DIV;
                alu_req.a  = r_dxy << 32;
                alu_req.b  = r_dxx;
            end
            STP_SLP_B: begin
                alu_req.op = ALU_DIV;
                alu_req.a  = r_dxy << 32;
                alu_req.b  = r_dyy;
            end
            STP_BELOW: begin
                alu_req.a = WIDE_W'(slope_beg);
                alu_req.b = WIDE_W'(r_ka - r_q);
            end
            STP_ABOVE: begin
                alu_req.a = WIDE_W'(slope_end);
                alu_req.b = WIDE_W'(r_q - r_ka);
            end
            STP_NUM: begin
                alu_req.a = WIDE_W'(r_va - r_vb);
                alu_req.b = WIDE_W'(r_q - r_kb);
            end
            STP_DIV: begin
                alu_req.op = ALU_DIV;
                alu_req.a  = num_sh;
                alu_req.b  = q_den;
            end
            default: begin
                alu_req.a = '0;
            end
        endcase
    end

    gmi_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_bp_value),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (pos_rd)
    );

    gmi_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_dist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_cm_value),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (dist_rd)
    );

    gmi_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STP_DXX;
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_slope[i] <= '0;
            end
        end else begin
            // S_DONE reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind   <= i_kind;
                        r_q      <= (i_kind == KIND_CM2BP) ? i_cm_value : i_bp_value;
                        r_res    <= '0;
                        r_sat    <= 1'b0;
                        r_status <= ST_DONE;
                        r_state  <= S_DONE;
                        case (i_kind)
                            KIND_CLEAR: begin
                                r_count <= '0;
                                r_ready <= 1'b0;
                                for (int i = 0; i < 4; i++) begin
                                    r_slope[i] <= '0;
                                end
                            end
                            KIND_LOAD: begin
                                if (r_count == DEPTH_CNT) begin
                                    r_status <= ST_FULL;
                                end else if (load_bad_order) begin
                                    r_status <= ST_ORDER;
                                end else begin
                                    r_last_bp <= i_bp_value;
                                    r_last_cm <= i_cm_value;
                                    r_count   <= r_count + 1'b1;
                                    r_ready   <= 1'b0;
                                end
                            end
                            KIND_FIT: begin
                                if (r_count == '0) begin
                                    r_status <= ST_UNFIT;
                                end else begin
                                    r_n        <= fit_n;
                                    r_end_base <= fit_e;
                                    r_base     <= '0;
                                    r_win      <= 1'b0;
                                    r_k        <= '0;
                                    r_sx       <= '0;
                                    r_sy       <= '0;
                                    r_sxx      <= '0;
                                    r_syy      <= '0;
                                    r_sxy      <= '0;
                                    r_state    <= S_FIT_RD;
                                end
                            end
                            KIND_BP2CM, KIND_CM2BP: begin
                                if ((r_count == '0) || !r_ready) begin
                                    r_status <= ST_UNFIT;
                                end else begin
                                    r_lo    <= '0;
                                    r_hi    <= r_count;
                                    r_state <= S_SRCH;
                                end
                            end
                            default: begin
                                r_status <= ST_DONE;
                            end
                        endcase
                    end
                end

                S_FIT_RD: r_state <= S_FIT_CAP;

                S_FIT_CAP: begin
                    // offsets are taken from the first point of the window
                    r_x0    <= cap_x0;
                    r_y0    <= cap_y0;
                    r_dx    <= pos_rd - cap_x0;
                    r_dy    <= dist_rd - cap_y0;
                    r_sx    <= r_sx + SX_W'(pos_rd - cap_x0);
                    r_sy    <= r_sy + SX_W'(dist_rd - cap_y0);
                    r_step  <= STP_DXX;
                    r_state <= S_ALU_GO;
                end

                S_ALU_GO: r_state <= S_ALU_WAIT;

                S_ALU_WAIT: begin
                    if (alu_rsp.done) begin
                        r_state <= S_ALU_GO;
                        case (r_step)
                            STP_DXX: begin
                                r_sxx  <= r_sxx + SQ_W'(alu_rsp.quo);
                                r_step <= STP_DYY;
                            end
                            STP_DYY: begin
                                r_syy  <= r_syy + SQ_W'(alu_rsp.quo);
                                r_step <= STP_DXY;
                            end
                            STP_DXY: begin
                                r_sxy <= r_sxy + SQ_W'(alu_rsp.quo);
                                if (r_k + 1'b1 == r_n) begin
                                    r_step <= STP_NSXX;
                                end else begin
                                    r_k     <= r_k + 1'b1;
                                    r_state <= S_FIT_RD;
                                end
                            end
                            STP_NSXX: begin
                                r_t1   <= alu_rsp.quo;
                                r_step <= STP_SXSX;
                            end
                            STP_SXSX: begin
                                r_dxx  <= r_t1 - alu_rsp.quo;
                                r_step <= STP_NSYY;
                            end
                            STP_NSYY: begin
                                r_t1   <= alu_rsp.quo;
                                r_step <= STP_SYSY;
                            end
                            STP_SYSY: begin
                                r_dyy  <= r_t1 - alu_rsp.quo;
                                r_step <= STP_NSXY;
                            end
                            STP_NSXY: begin
                                r_t1   <= alu_rsp.quo;
                                r_step <= STP_SXSY;
                            end
                            STP_SXSY: begin
                                r_dxy   <= r_t1 - alu_rsp.quo;
                                r_step  <= STP_SLP_A;
                                r_state <= S_SLOPE;
                            end
                            STP_SLP_A: begin
                                r_slope[{r_win, 1'b0}] <= f_sat(alu_rsp.quo);
                                r_step  <= STP_SLP_B;
                                r_state <= S_SLOPE;
                            end
                            STP_SLP_B: begin
                                r_slope[{r_win, 1'b1}] <= f_sat(alu_rsp.quo);
                                r_state <= S_WEND;
                            end
                            STP_BELOW: begin
                                r_status <= ST_BELOW;
                                r_state  <= S_DONE;
                                if (q_base < alu_rsp.quo) begin
                                    r_res <= '0;
                                    r_sat <= 1'b1;
                                end else begin
                                    r_res <= q_below[BPR_W-1:0];
                                end
                            end
                            STP_ABOVE: begin
                                r_status <= ST_ABOVE;
                                r_state  <= S_DONE;
                                if (q_above > q_max) begin
                                    r_res <= q_max[BPR_W-1:0];
                                    r_sat <= 1'b1;
                                end else begin
                                    r_res <= q_above[BPR_W-1:0];
                                end
                            end
                            STP_NUM: begin
                                r_t1   <= alu_rsp.quo;
                                r_step <= STP_DIV;
                            end
                            STP_DIV: begin
                                r_res    <= q_interp[BPR_W-1:0];
                                r_status <= ST_INTERP;
                                r_state  <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end

                S_SLOPE: begin
                    // a zero denominator gives a zero slope without dividing
                    r_state <= S_ALU_GO;
                    case (r_step)
                        STP_SLP_A: begin
                            if (r_dxx == '0) begin
                                r_slope[{r_win, 1'b0}] <= '0;
                                r_step  <= STP_SLP_B;
                                r_state <= S_SLOPE;
                            end
                        end
                        STP_SLP_B: begin
                            if (r_dyy == '0) begin
                                r_slope[{r_win, 1'b1}] <= '0;
                                r_state <= S_WEND;
                            end
                        end
                        default: r_state <= S_WEND;
                    endcase
                end

                S_WEND: begin
                    if (!r_win) begin
                        r_win   <= 1'b1;
                        r_base  <= r_end_base;
                        r_k     <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_sxx   <= '0;
                        r_syy   <= '0;
                        r_sxy   <= '0;
                        r_state <= S_FIT_RD;
                    end else begin
                        r_ready <= 1'b1;
                        r_state <= S_DONE;
                    end
                end

                S_SRCH: r_state <= (r_lo < r_hi) ? S_CMP : S_QA;

                S_CMP: begin
                    if (key < r_q) begin
                        r_lo <= mid + 1'b1;
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= S_SRCH;
                end

                S_QA: begin
                    r_ka <= key;
                    r_va <= val;
                    if ((r_lo < r_count) && (key == r_q)) begin
                        r_res    <= is_bp ? (BPR_W'(val) << FRAC_BP) : BPR_W'(val);
                        r_status <= ST_EXACT;
                        r_state  <= S_DONE;
                    end else if (r_lo == '0) begin
                        r_step  <= STP_BELOW;
                        r_state <= S_ALU_GO;
                    end else if (r_lo == r_count) begin
                        r_step  <= STP_ABOVE;
                        r_state <= S_ALU_GO;
                    end else begin
                        r_state <= S_QB;
                    end
                end

                S_QB: begin
                    r_kb    <= key;
                    r_vb    <= val;
                    r_step  <= STP_NUM;
                    r_state <= S_ALU_GO;
                end

                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_cm      <= (r_kind == KIND_BP2CM) ? r_res[CMR_W-1:0] : '0;
                        r_o_bp      <= (r_kind == KIND_CM2BP) ? r_res : '0;
                        r_o_status  <= r_status;
                        r_o_sat     <= r_sat;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cm_result = r_o_cm;
    assign o_bp_result = r_o_bp;
    assign o_status    = r_o_status;
    assign o_saturated = r_o_sat;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("point count beyond table depth");

    a_alu_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_ALU_WAIT))
        else $error("shared unit finished while nobody waited");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH || r_state == S_CMP) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("binary search bounds out of order");

    a_sat_edges_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_status == ST_BELOW || o_status == ST_ABOVE))
        else $error("saturation flagged inside the table");

    a_answer_needs_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (r_status == ST_EXACT || r_status == ST_INTERP ||
         r_status == ST_BELOW || r_status == ST_ABOVE)) |-> (r_ready && r_count != '0))
        else $error("query answered without a current fit");

endmodule

@@ bench/gmi_checker.sv @@
// gmi_checker: watches both channels of genetic_map_interpolator, predicts
// each result from its own copy of the map table and compares. Uses gmi_pkg.
module gmi_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [gmi_pkg::KIND_W-1:0]        i_kind,
    input  logic [gmi_pkg::VAL_W-1:0]         i_bp_value,
    input  logic [gmi_pkg::VAL_W-1:0]         i_cm_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [gmi_pkg::CMR_W-1:0]         i_cm_result,
    input  logic [gmi_pkg::BPR_W-1:0]         i_bp_result,
    input  logic [gmi_pkg::STATUS_W-1:0]      i_status,
    input  logic                              i_saturated,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gmi_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int WIN   = LOOKBACK_DEF;

    typedef struct {
        logic [CMR_W-1:0]    cm;
        logic [BPR_W-1:0]    bp;
        logic [STATUS_W-1:0] st;
        logic                sat;
    } t_answer;

    logic [31:0]  map_bp [DEPTH];
    logic [31:0]  map_cm [DEPTH];
    int unsigned  n_points;
    logic [63:0]  slope [4];
    bit           fitted;
    t_answer      answers_due [$];
    int           n_err = 0;
    int           n_due = 0;

    function automatic logic [31:0] key_at(bit by_cm, int unsigned i);
        return by_cm ? map_cm[i] : map_bp[i];
    endfunction

    // least-squares slope of y over x in window [start, start+n)
    function automatic logic [63:0] lsq_slope(bit by_cm, int unsigned start, int unsigned n);
        logic [31:0]  x0, y0, d32;
        logic [63:0]  dx, dy, sx, sy;
        logic [127:0] sxx, sxy, dxx, dxy, quo;
        x0 = key_at(by_cm, start);
        y0 = key_at(!by_cm, start);
        sx = 0; sy = 0; sxx = 0; sxy = 0;
        for (int unsigned k = 0; k < n; k++) begin
            d32 = key_at(by_cm, start + k) - x0;
            dx = d32;
            d32 = key_at(!by_cm, start + k) - y0;
            dy = d32;
            sx += dx;
            sy += dy;
            sxx += 128'(dx) * 128'(dx);
            sxy += 128'(dx) * 128'(dy);
        end
        dxx = sxx * 128'(n) - 128'(sx) * 128'(sx);
        dxy = sxy * 128'(n) - 128'(sx) * 128'(sy);
        if (dxx == 0) return 64'd0;
        quo = (dxy << 32) / dxx;
        return (quo[127:64] != 0) ? {64{1'b1}} : quo[63:0];
    endfunction

    // table search plus interpolation / extrapolation; returns status code
    function automatic logic [STATUS_W-1:0] convert(bit by_cm, logic [31:0] q,
            logic [63:0] s_beg, logic [63:0] s_end, int frac, logic [63:0] maxv,
            output logic [63:0] res, output logic sat);
        int unsigned  lo, hi, mid;
        logic [31:0]  d32, dv;
        logic [63:0]  den, num, q0, rm, f, fq, fr;
        logic [127:0] half, base, prod, x, r;
        res = 0; sat = 0;
        lo = 0; hi = n_points;
        half = 128'(1) << (31 - frac);
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_at(by_cm, mid) < q) lo = mid + 1; else hi = mid;
        end
        if (lo < n_points && key_at(by_cm, lo) == q) begin
            res = 64'(key_at(!by_cm, lo)) << frac;
            return ST_EXACT;
        end
        if (lo == 0) begin
            base = 128'(key_at(!by_cm, 0)) << 32;
            d32 = key_at(by_cm, 0) - q;
            prod = 128'(s_beg) * 128'(d32);
            if (base < prod) begin
                sat = 1;
            end else begin
                r = (base - prod + half) >> (32 - frac);
                res = r[63:0];
            end
            return ST_BELOW;
        end
        if (lo == n_points) begin
            d32 = q - key_at(by_cm, n_points - 1);
            x = (128'(key_at(!by_cm, n_points - 1)) << 32) + 128'(s_end) * 128'(d32);
            r = (x + half) >> (32 - frac);
            if (r > 128'(maxv)) begin
                res = maxv;
                sat = 1;
            end else begin
                res = r[63:0];
            end
            return ST_ABOVE;
        end
        d32 = key_at(by_cm, lo) - key_at(by_cm, lo - 1);
        den = d32;
        dv = key_at(!by_cm, lo) - key_at(!by_cm, lo - 1);
        d32 = q - key_at(by_cm, lo - 1);
        num = 64'(dv) * 64'(d32);
        q0 = num / den;
        rm = num % den;
        f = rm << frac;
        fq = f / den;
        fr = f % den;
        if (2 * fr >= den) fq++;
        res = (64'(key_at(!by_cm, lo - 1)) << frac) + (q0 << frac) + fq;
        return ST_INTERP;
    endfunction

    // apply one transaction to the model state and return its answer
    function automatic t_answer predict_answer(logic [KIND_W-1:0] kind,
            logic [31:0] bp, logic [31:0] cm);
        t_answer     a;
        logic [63:0] res;
        logic        sat;
        int unsigned n;
        a = '{cm: '0, bp: '0, st: ST_DONE, sat: 1'b0};
        case (kind)
            KIND_CLEAR: begin
                n_points = 0;
                slope = '{default: '0};
                fitted = 0;
            end
            KIND_LOAD: begin
                if (n_points >= DEPTH) a.st = ST_FULL;
                else if (n_points > 0 && (bp <= map_bp[n_points-1] ||
                                          cm <= map_cm[n_points-1])) a.st = ST_ORDER;
                else begin
                    map_bp[n_points] = bp;
                    map_cm[n_points] = cm;
                    n_points++;
                    fitted = 0;
                end
            end
            KIND_FIT: begin
                if (n_points == 0) a.st = ST_UNFIT;
                else begin
                    n = (n_points < WIN) ? n_points : WIN;
                    slope[SLP_BEG_CM] = lsq_slope(0, 0, n);
                    slope[SLP_BEG_BP] = lsq_slope(1, 0, n);
                    slope[SLP_END_CM] = lsq_slope(0, n_points - n, n);
                    slope[SLP_END_BP] = lsq_slope(1, n_points - n, n);
                    fitted = 1;
                end
            end
            KIND_BP2CM, KIND_CM2BP: begin
                if (n_points == 0 || !fitted) a.st = ST_UNFIT;
                else if (kind == KIND_BP2CM) begin
                    a.st = convert(0, bp, slope[SLP_BEG_CM], slope[SLP_END_CM], 0,
                                   64'hFFFF_FFFF, res, sat);
                    a.cm = res[31:0];
                    a.sat = sat;
                end else begin
                    a.st = convert(1, cm, slope[SLP_BEG_BP], slope[SLP_END_BP], FRAC_BP,
                                   64'hFF_FFFF_FFFF, res, sat);
                    a.bp = res[39:0];
                    a.sat = sat;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    initial begin
        n_points = 0;
        fitted = 0;
        slope = '{default: '0};
    end

    assign o_fail_count = n_err;
    assign o_pending    = n_due;

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n) begin
            // retire results first, then queue the new item's answer
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("result with no transaction outstanding");
                    n_err++;
                end else begin
                    e = answers_due.pop_front();
                    if (i_cm_result !== e.cm) begin
                        $error("cm_result: expected %h, got %h", e.cm, i_cm_result);
                        n_err++;
                    end
                    if (i_bp_result !== e.bp) begin
                        $error("bp_result: expected %h, got %h", e.bp, i_bp_result);
                        n_err++;
                    end
                    if (i_status !== e.st) begin
                        $error("status: expected %0d, got %0d", e.st, i_status);
                        n_err++;
                    end
                    if (i_saturated !== e.sat) begin
                        $error("saturated: expected %0d, got %0d", e.sat, i_saturated);
                        n_err++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                answers_due.push_back(predict_answer(i_kind, i_bp_value, i_cm_value));
            n_due = answers_due.size();
        end
    end
endmodule

@@ bench/tb_top.sv @@
// tb_top: stimulus and verdict for genetic_map_interpolator.
// Depends on gmi_pkg, the block's RTL and gmi_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gmi_pkg::*;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                in_valid = 0;
    logic                in_stall;
    logic [KIND_W-1:0]   kind = KIND_CLEAR;
    logic [VAL_W-1:0]    bp_value = '0;
    logic [VAL_W-1:0]    cm_value = '0;
    logic                out_valid;
    logic                out_stall = 0;
    logic [CMR_W-1:0]    cm_result;
    logic [BPR_W-1:0]    bp_result;
    logic [STATUS_W-1:0] status;
    logic                saturated;
    int                  fail_count;
    int                  pending;

    // stimulus-side view of the loaded points, used to aim queries
    logic [31:0] pts_bp [$];
    logic [31:0] pts_cm [$];
    int          n_sent;
    bit          quiet;         // no sender gaps in this stretch
    bit          hold_req;      // asks the receiver for its one long hold-off
    bit          hold_done;

    always #1 i_clk = ~i_clk;

    genetic_map_interpolator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_kind      (kind),
        .i_bp_value  (bp_value),
        .i_cm_value  (cm_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_cm_result (cm_result),
        .o_bp_result (bp_result),
        .o_status    (status),
        .o_saturated (saturated)
    );

    gmi_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_kind       (kind),
        .i_bp_value   (bp_value),
        .i_cm_value   (cm_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_cm_result  (cm_result),
        .i_bp_result  (bp_result),
        .i_status     (status),
        .i_saturated  (saturated),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one input transaction; called at a falling edge, returns at one
    task automatic send(logic [KIND_W-1:0] k, logic [31:0] bp, logic [31:0] cm);
        int g;
        g = quiet ? 0 : idle_len();
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        in_valid <= 1;
        kind     <= k;
        bp_value <= bp;
        cm_value <= cm;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic do_clear();
        send(KIND_CLEAR, $urandom, $urandom);
        pts_bp.delete();
        pts_cm.delete();
    endtask

    // one load; the stimulus records the point only if it is in order and the table not full
    task automatic load_pt(logic [31:0] bp, logic [31:0] cm);
        send(KIND_LOAD, bp, cm);
        if (pts_bp.size() < TABLE_DEPTH_DEF &&
            (pts_bp.size() == 0 || (bp > pts_bp[$] && cm > pts_cm[$]))) begin
            pts_bp.push_back(bp);
            pts_cm.push_back(cm);
        end
    endtask

    // pick a query key aimed at one region of the table
    function automatic logic [31:0] aim_key(bit by_cm);
        logic [31:0] lo_k, hi_k;
        int          i;
        if (by_cm) begin lo_k = pts_cm[0]; hi_k = pts_cm[$]; end
        else begin lo_k = pts_bp[0]; hi_k = pts_bp[$]; end
        i = $urandom_range(0, pts_bp.size() - 1);
        case ($urandom_range(0, 7))
            0, 1:    return by_cm ? pts_cm[i] : pts_bp[i];           // exact hit
            2, 3:    return lo_k + 32'($urandom_range(0, 32'(hi_k - lo_k)));
            4:       return (lo_k == 0) ? 32'd0 : 32'($urandom_range(0, lo_k - 1));
            5:       return (hi_k == '1) ? hi_k : hi_k + 32'($urandom_range(1, ~hi_k));
            6:       return $urandom;
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    task automatic query(bit by_cm);
        if (by_cm) send(KIND_CM2BP, $urandom, aim_key(1));
        else send(KIND_BP2CM, aim_key(0), $urandom);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int len;
        hold_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1;
                repeat (400) @(negedge i_clk);
                hold_done = 1;
            end else begin
                len = idle_len();
                if (len > 0) begin
                    out_stall <= 1;
                    repeat (len) @(negedge i_clk);
                end
                out_stall <= 0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int          n, m;
        logic [31:0] b, c, bstep, cstep;
        n_sent = 0;
        quiet = 0;
        hold_req = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty table, unused kinds, ordering rules, edges of range
        send(KIND_CLEAR, 32'h0, 32'h0);
        send(KIND_BP2CM, 32'h0, 32'h0);
        send(KIND_CM2BP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_FIT, 32'h0, 32'h0);
        send(3'd5, 32'hFFFF_FFFF, 32'h0);
        send(3'd6, 32'h0, 32'hFFFF_FFFF);
        send(3'd7, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        load_pt(32'd0, 32'd0);
        load_pt(32'd0, 32'd10);                 // bp not above last point
        load_pt(32'd10, 32'd0);                 // cM not above last point
        load_pt(32'd1000, 32'd5000);
        load_pt(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_BP2CM, 32'd500, 32'h0);      // loaded but not fitted
        send(KIND_FIT, 32'h0, 32'h0);
        send(KIND_BP2CM, 32'd0, 32'h0);
        send(KIND_BP2CM, 32'd500, 32'h0);
        send(KIND_BP2CM, 32'hFFFF_FFFF, 32'h0);
        send(KIND_CM2BP, 32'h0, 32'd2500);
        send(KIND_CM2BP, 32'h0, 32'd5000);
        send(KIND_CM2BP, 32'h0, 32'h8000_0001);
        do_clear();
        load_pt(32'd100, 32'd200);
        send(KIND_FIT, 32'h0, 32'h0);          // single point: zero slopes
        send(KIND_BP2CM, 32'd5, 32'h0);
        send(KIND_CM2BP, 32'h0, 32'hFFFF_FFFF);

        // random map sets: clear, ascending loads with some noise, fit, queries
        hold_req = 1;
        while (n_sent < 950) begin
            quiet = ($urandom_range(0, 5) == 0);
            do_clear();
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 6);
            b = $urandom_range(0, 32'h7FFF_FFFF);
            c = $urandom_range(0, 32'h7FFF_FFFF);
            bstep = 32'd1 << $urandom_range(0, 24);
            cstep = 32'd1 << $urandom_range(0, 24);
            for (int i = 0; i < n; i++) begin
                load_pt(b, c);
                if ($urandom_range(0, 9) == 0)
                    load_pt(b - 32'($urandom_range(0, 3)), $urandom);   // out of order
                b += 32'($urandom_range(1, bstep));
                c += 32'($urandom_range(1, cstep));
            end
            if ($urandom_range(0, 4) == 0) query($urandom_range(0, 1));
            send(KIND_FIT, $urandom, $urandom);
            m = $urandom_range(6, 14);
            for (int i = 0; i < m; i++) begin
                case ($urandom_range(0, 19))
                    0:       send(3'($urandom_range(5, 7)), $urandom, $urandom);
                    1:       send(KIND_FIT, $urandom, $urandom);
                    default: query($urandom_range(0, 1));
                endcase
            end
        end

        quiet = 0;
        send(KIND_FIT, 32'h0, 32'h0);
        for (int i = 0; i < 12; i++) query(i % 2);
        in_valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/gmi_pkg.sv
sv/gmi_ram.sv
sv/gmi_alu.sv
sv/genetic_map_interpolator.sv
bench/gmi_checker.sv
bench/tb_top.sv
